/* hw/rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// Positional array list engine package
// Shared types, codes and constants for the list cells, the match encoder
// and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int CNT_W            = 7;
  localparam int DATA_W           = 32;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_SEARCH   = 2'd2,
    KIND_TRAVERSE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ELEMENT  = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH1,
    S_SRCH2,
    S_TRAV
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [CNT_W-1:0]        found_position;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    cell_op_t                op;
    logic [CNT_W-1:0]        index;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        tail;
    logic [DATA_W-1:0]       value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/pal_cell.sv */
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry. Moves it towards either neighbour on insert, delete
// and rotation, and registers whether it matches the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell #(
  parameter int Idx = 0
) (
  input  wire logic                        clk,
  input  wire pal_pkg::cell_ctrl_t         ctrl,
  input  wire logic [pal_pkg::DATA_W-1:0]  left,
  input  wire logic [pal_pkg::DATA_W-1:0]  right,
  input  wire logic [pal_pkg::DATA_W-1:0]  head,
  output logic      [pal_pkg::DATA_W-1:0]  data,
  output logic                             match
);
  import pal_pkg::*;

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(Idx);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_INSERT: begin
        if (ctrl.index == IdxC) begin
          data_next = ctrl.value;
        end else if (ctrl.index < IdxC) begin
          data_next = left;
        end
      end
      CELL_DELETE: begin
        if (ctrl.index <= IdxC) begin
          data_next = right;
        end
      end
      CELL_ROTATE: begin
        if (ctrl.tail == IdxC) begin
          data_next = head;
        end else if (IdxC < ctrl.tail) begin
          data_next = right;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data  <= data_next;
    match <= (data == ctrl.value) && (IdxC < ctrl.count);
  end

endmodule

`default_nettype wire

/* hw/rtl/pal_search.sv */
// ----------------------------------------------------------------------------
// Match encoder
// Finds the first matching cell in two steps: first within groups of eight
// cells, which is registered, then across the groups.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_search #(
  parameter int Capacity = pal_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic [Capacity-1:0]        match,
  output logic                            hit,
  output logic      [pal_pkg::CNT_W-1:0]  hit_pos
);
  import pal_pkg::*;

  localparam int NGroup = (Capacity + 7) / 8;

  logic [NGroup*8-1:0] match_pad;
  logic [NGroup-1:0]   grp_any;
  logic [2:0]          grp_first [NGroup];
  logic [NGroup-1:0]   grp_any_next;
  logic [2:0]          grp_first_next [NGroup];

  assign match_pad = (NGroup*8)'(match);

  always_comb begin
    for (int g = 0; g < NGroup; g++) begin
      grp_any_next[g]   = 1'b0;
      grp_first_next[g] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (match_pad[g*8+j]) begin
          grp_any_next[g]   = 1'b1;
          grp_first_next[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any   <= grp_any_next;
    grp_first <= grp_first_next;
  end

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int g = NGroup - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        hit     = 1'b1;
        hit_pos = CNT_W'(g * 8) + {{(CNT_W-3){1'b0}}, grp_first[g]} + CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/positional_array_list_engine.sv */
// ----------------------------------------------------------------------------
// Positional array list engine
// Ordered list of signed words held in a chain of cells, with positional
// insert and delete, first-match search and in-order traversal.
// ----------------------------------------------------------------------------
// Insert and delete: result from the execute state; no new word is taken
// until the result is issued. Search: the match flags registered in the cells
// and the group results registered in the match encoder come first. Traverse:
// one element per cycle from the head cell as the chain rotates, unless stalled.
// Reset clears the count and the control state; the cells are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_engine #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pal_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pal_pkg::out_word_t      out_data
);
  import pal_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t            state, state_next;
  in_word_t          item;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  trav_idx, trav_idx_next;
  logic              out_free;
  logic              emit;
  out_word_t         res;
  cell_op_t          cell_op;
  cell_ctrl_t        ctrl;
  logic              is_full, ins_bad, del_bad, trav_last;
  logic [CNT_W-1:0]  trav_pos;
  logic              hit;
  logic [CNT_W-1:0]  hit_pos;

  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  assign out_free  = !out_valid || out_ready;
  assign is_full   = (count >= CNT_W'(CAPACITY));
  assign ins_bad   = (item.position == '0) ||
                     ({1'b0, item.position} > ({1'b0, count} + (CNT_W+1)'(1)));
  assign del_bad   = (item.position == '0) || (item.position > count);
  assign trav_pos  = {{(CNT_W-IDX_W){1'b0}}, trav_idx} + CNT_W'(1);
  assign trav_last = (trav_pos == count);

  always_comb begin
    ctrl.op    = cell_op;
    ctrl.index = item.position - CNT_W'(1);
    ctrl.count = count;
    ctrl.tail  = count - CNT_W'(1);
    ctrl.value = item.value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cell_data[0];
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end
    pal_cell #(.Idx(i)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .head  (cell_data[0]),
      .data  (cell_data[i]),
      .match (cell_match[i])
    );
  end

  pal_search #(.Capacity(CAPACITY)) u_search (
    .clk     (clk),
    .match   (cell_match),
    .hit     (hit),
    .hit_pos (hit_pos)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item.kind == KIND_SEARCH) begin
          state_next = S_SRCH1;
        end else if (item.kind == KIND_TRAVERSE && count != '0) begin
          state_next = S_TRAV;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SRCH1: state_next = S_SRCH2;
      S_SRCH2: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_TRAV: begin
        if (out_free && trav_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == S_IDLE);
    emit            = 1'b0;
    cell_op         = CELL_HOLD;
    count_next      = count;
    trav_idx_next   = trav_idx;
    res             = '0;
    res.last        = 1'b1;
    res.entry_count = count;
    unique case (state)
      S_IDLE: begin
        trav_idx_next = '0;
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (item.kind)
            KIND_INSERT: begin
              emit = 1'b1;
              if (is_full) begin
                res.status = ST_FULL;
              end else if (ins_bad) begin
                res.status = ST_BADPOS;
              end else begin
                cell_op         = CELL_INSERT;
                count_next      = count + CNT_W'(1);
                res.status      = ST_DONE;
                res.entry_count = count_next;
              end
            end
            KIND_DELETE: begin
              emit = 1'b1;
              if (del_bad) begin
                res.status = ST_BADPOS;
              end else begin
                cell_op         = CELL_DELETE;
                count_next      = count - CNT_W'(1);
                res.status      = ST_DONE;
                res.entry_count = count_next;
              end
            end
            KIND_SEARCH: begin
            end
            KIND_TRAVERSE: begin
              if (count == '0) begin
                emit       = 1'b1;
                res.status = ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH1: begin
      end
      S_SRCH2: begin
        if (out_free) begin
          emit = 1'b1;
          if (hit) begin
            res.status         = ST_FOUND;
            res.found_position = hit_pos;
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
      end
      S_TRAV: begin
        if (out_free) begin
          emit               = 1'b1;
          cell_op            = CELL_ROTATE;
          trav_idx_next      = trav_idx + IDX_W'(1);
          res.status         = ST_ELEMENT;
          res.found_position = trav_pos;
          res.element        = cell_data[0];
          res.last           = trav_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      trav_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      trav_idx <= trav_idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (emit) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_trav_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_TRAV |-> count != '0)
    else $error("traversal running on an empty list");

  a_trav_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_ELEMENT && out_data.last
      |-> out_data.found_position == out_data.entry_count)
    else $error("final traversal word not at the last position");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FOUND
      |-> out_data.found_position != '0 &&
          out_data.found_position <= out_data.entry_count)
    else $error("search hit outside the stored entries");
`endif

endmodule

`default_nettype wire

/* sim/positional_array_list_engine_tb.sv */
// ----------------------------------------------------------------------------
// Positional array list engine testbench
// Feeds insert, delete, search and traverse words through the valid/ready
// input and checks every result word against a queue-based copy of the list
// held here, with random gaps on the sender side and stalls on the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module positional_array_list_engine_tb;
  import pal_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEFAULT;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    in_word_t word;
    bit       settle;
  } stim_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  stim_t                    pending_words[$];
  out_word_t                expected_results[$];
  logic signed [DATA_W-1:0] list_shadow[$];
  out_word_t                oldest;
  int                       gen_count;
  int                       gap_left;
  int                       burst_left;
  int                       quiet_cycles;
  logic [31:0]              rx_cycle;
  bit                       failed;

  positional_array_list_engine #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void expect_result(status_t st, int pos, logic signed [DATA_W-1:0] el,
                                        logic lst);
    out_word_t r;
    r.status         = st;
    r.found_position = pos[CNT_W-1:0];
    r.element        = el;
    r.entry_count    = CNT_W'(list_shadow.size());
    r.last           = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_list_op(in_word_t w);
    int p;
    int n;
    int found_at;
    p = w.position;
    n = list_shadow.size();
    case (kind_t'(w.kind))
      KIND_INSERT: begin
        if (n >= LIST_CAP) begin
          expect_result(ST_FULL, 0, 0, 1'b1);
        end else if (p < 1 || p > n + 1) begin
          expect_result(ST_BADPOS, 0, 0, 1'b1);
        end else begin
          list_shadow.insert(p - 1, w.value);
          expect_result(ST_DONE, 0, 0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (p < 1 || p > n) begin
          expect_result(ST_BADPOS, 0, 0, 1'b1);
        end else begin
          list_shadow.delete(p - 1);
          expect_result(ST_DONE, 0, 0, 1'b1);
        end
      end
      KIND_SEARCH: begin
        found_at = 0;
        for (int i = 0; i < n; i++) begin
          if (found_at == 0 && list_shadow[i] == w.value) found_at = i + 1;
        end
        if (found_at != 0) expect_result(ST_FOUND, found_at, 0, 1'b1);
        else expect_result(ST_NOTFOUND, 0, 0, 1'b1);
      end
      default: begin
        if (n == 0) begin
          expect_result(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) expect_result(ST_ELEMENT, i + 1, list_shadow[i], i == n - 1);
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      3: return 0;
      4, 5, 6: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(kind_t k, logic signed [DATA_W-1:0] v, int p, bit settle = 1'b0);
    stim_t s;
    s.word.kind     = k;
    s.word.value    = v;
    s.word.position = p[CNT_W-1:0];
    s.settle        = settle;
    pending_words.push_back(s);
    if (k == KIND_INSERT && gen_count < LIST_CAP && p >= 1 && p <= gen_count + 1) gen_count++;
    if (k == KIND_DELETE && p >= 1 && p <= gen_count) gen_count--;
  endtask

  task automatic random_op();
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, gen_count + 1);
      push_word(KIND_INSERT, pick_value(), p);
    end else if (r < 62) begin
      p = ($urandom_range(0, 9) == 0 || gen_count == 0) ? $urandom_range(0, 127)
                                                        : $urandom_range(1, gen_count);
      push_word(KIND_DELETE, $urandom, p);
    end else if (r < 88) begin
      push_word(KIND_SEARCH, pick_value(), $urandom_range(0, 127));
    end else begin
      push_word(KIND_TRAVERSE, $urandom, $urandom_range(0, 127));
    end
  endtask

  initial begin
    gen_count = 0;
    failed    = 1'b0;

    push_word(KIND_TRAVERSE, 0, 0);
    push_word(KIND_DELETE, 0, 1);
    push_word(KIND_DELETE, 0, 0);
    push_word(KIND_SEARCH, 0, 0);
    push_word(KIND_INSERT, 1, 0);
    push_word(KIND_INSERT, 1, 2);
    push_word(KIND_INSERT, 32'sh8000_0000, 1);
    push_word(KIND_INSERT, 32'sh7fff_ffff, 2);
    push_word(KIND_INSERT, -1, 1);
    push_word(KIND_INSERT, 0, 2);
    push_word(KIND_INSERT, 5, 127);
    push_word(KIND_SEARCH, 32'sh7fff_ffff, 0);
    push_word(KIND_SEARCH, 5, 0);
    push_word(KIND_SEARCH, -1, 127);
    push_word(KIND_DELETE, 0, 0);
    push_word(KIND_DELETE, 0, 5);
    push_word(KIND_DELETE, 0, 127);
    push_word(KIND_TRAVERSE, 0, 0);
    push_word(KIND_DELETE, 0, 2);
    push_word(KIND_DELETE, 0, 3);
    push_word(KIND_DELETE, 0, 1);
    push_word(KIND_INSERT, 32'sh5555_5555, 2);
    push_word(KIND_INSERT, 32'shAAAA_AAAA, 1);
    push_word(KIND_TRAVERSE, 0, 0);

    repeat (20) random_op();

    // The list is filled to capacity once the block has gone quiet.
    push_word(KIND_SEARCH, pick_value(), 0, 1'b1);
    while (gen_count < LIST_CAP) push_word(KIND_INSERT, pick_value(), $urandom_range(1, gen_count + 1));
    push_word(KIND_INSERT, pick_value(), 0);
    push_word(KIND_INSERT, pick_value(), $urandom_range(1, LIST_CAP));
    push_word(KIND_TRAVERSE, 0, 0);
    push_word(KIND_SEARCH, pick_value(), 0);
    push_word(KIND_DELETE, 0, LIST_CAP + 1);
    push_word(KIND_DELETE, 0, LIST_CAP);

    repeat (20) random_op();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (40) @(posedge clk);

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].settle && (in_valid || expected_results.size() != 0))) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_words[0].word;
        in_valid <= 1'b1;
        pending_words.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_cycle  = 0;
    end else begin
      rx_cycle++;
      case (rx_cycle[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= (rx_cycle[2:0] < 3'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d, element %0h", out_data.status,
                 out_data.element);
          failed = 1'b1;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("status", DATA_W'(oldest.status), DATA_W'(out_data.status));
          compare_field("found_position", DATA_W'(oldest.found_position),
                        DATA_W'(out_data.found_position));
          compare_field("element", oldest.element, out_data.element);
          compare_field("entry_count", DATA_W'(oldest.entry_count),
                        DATA_W'(out_data.entry_count));
          compare_field("last", DATA_W'(oldest.last), DATA_W'(out_data.last));
        end
      end
      if (in_valid && in_ready) predict_list_op(in_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sim.f */
hw/rtl/pal_pkg.sv
hw/rtl/pal_cell.sv
hw/rtl/pal_search.sv
hw/rtl/positional_array_list_engine.sv
sim/positional_array_list_engine_tb.sv
